// ===== rtl/core/aabb_pkg.sv =====
package aabb_pkg;

   localparam int DAMP_DIVISOR = 10;
   localparam int E_ONE = 256;

   localparam int NUM_WIDTH = 42;
   localparam int DEN_WIDTH = 31;
   localparam int QUO_WIDTH = 18;

   localparam logic [DEN_WIDTH-1:0] DEN_SCALE = DEN_WIDTH'(E_ONE * DAMP_DIVISOR);
   localparam logic [DEN_WIDTH-1:0] HALF_SCALE = DEN_WIDTH'(E_ONE * DAMP_DIVISOR / 2);

   typedef struct packed {
      logic        vld;
      logic        hit;
      logic        axis_y;
      logic        neg;
      logic        act;
      logic [15:0] pen;
   } aabb_meta_type;

   typedef struct packed {
      aabb_meta_type meta;
      logic [15:0]   ma;
      logic [15:0]   mb;
   } aabb_geo_type;

   // round magnitude is already in q; apply sign and clip to 16 bits
   function automatic logic [15:0] sat16(input logic [QUO_WIDTH-1:0] q, input logic ng);
      logic [QUO_WIDTH-1:0] lim;
      logic [QUO_WIDTH-1:0] mag;
      logic [QUO_WIDTH-1:0] res;
      lim = ng ? QUO_WIDTH'(32768) : QUO_WIDTH'(32767);
      mag = (q > lim) ? lim : q;
      res = ng ? (~mag + QUO_WIDTH'(1)) : mag;
      return res[15:0];
   endfunction

endpackage

// ===== rtl/core/aabb_geom.sv =====
module aabb_geom (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       vld_in,
   input  logic signed [15:0]         a_cx,
   input  logic signed [15:0]         a_cy,
   input  logic [14:0]                a_w,
   input  logic [14:0]                a_h,
   input  logic signed [15:0]         b_cx,
   input  logic signed [15:0]         b_cy,
   input  logic [14:0]                b_w,
   input  logic [14:0]                b_h,
   input  logic [15:0]                a_m,
   input  logic [15:0]                b_m,
   output aabb_pkg::aabb_geo_type     geo
);

   aabb_pkg::aabb_geo_type geo_ff, geo_in;

   logic signed [18:0] ax2, ay2, bx2, by2, aw, ah, bw, bh;
   logic signed [16:0] dx, dy;
   logic [16:0]        adx, ady;
   logic signed [17:0] ox, oy;
   logic               hit, ox_pos, oy_pos;

   always_comb begin
      ax2 = {{2{a_cx[15]}}, a_cx, 1'b0};
      ay2 = {{2{a_cy[15]}}, a_cy, 1'b0};
      bx2 = {{2{b_cx[15]}}, b_cx, 1'b0};
      by2 = {{2{b_cy[15]}}, b_cy, 1'b0};
      aw = {4'b0, a_w};
      ah = {4'b0, a_h};
      bw = {4'b0, b_w};
      bh = {4'b0, b_h};
      // doubled half-extent test stays exact
      hit = !((ax2 + aw < bx2 - bw) || (bx2 + bw < ax2 - aw) ||
              (ay2 + ah < by2 - bh) || (by2 + bh < ay2 - ah));
      dx = {a_cx[15], a_cx} - {b_cx[15], b_cx};
      dy = {a_cy[15], a_cy} - {b_cy[15], b_cy};
      adx = dx[16] ? 17'(-dx) : 17'(dx);
      ady = dy[16] ? 17'(-dy) : 17'(dy);
      ox = $signed({3'b0, a_w}) + $signed({3'b0, b_w}) - $signed({1'b0, adx});
      oy = $signed({3'b0, a_h}) + $signed({3'b0, b_h}) - $signed({1'b0, ady});
      ox_pos = !ox[17] && (ox != '0);
      oy_pos = !oy[17] && (oy != '0);

      geo_in.meta.vld    = vld_in;
      geo_in.meta.hit    = hit;
      geo_in.meta.axis_y = 1'b0;
      geo_in.meta.neg    = 1'b0;
      geo_in.meta.pen    = '0;
      geo_in.meta.act    = 1'b0;
      if (hit && ox_pos && oy_pos) begin
         if (ox < oy) begin
            geo_in.meta.neg = dx[16];
            geo_in.meta.pen = ox[15:0];
         end else begin
            geo_in.meta.axis_y = 1'b1;
            geo_in.meta.neg    = dy[16];
            geo_in.meta.pen    = oy[15:0];
         end
         geo_in.meta.act = (a_m != '0) || (b_m != '0);
      end
      geo_in.ma = a_m;
      geo_in.mb = b_m;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_ff.meta.vld <= 1'b0;
      end else if (en) begin
         geo_ff.meta.vld <= geo_in.meta.vld;
      end
      if (en) begin
         geo_ff.meta.hit    <= geo_in.meta.hit;
         geo_ff.meta.axis_y <= geo_in.meta.axis_y;
         geo_ff.meta.neg    <= geo_in.meta.neg;
         geo_ff.meta.act    <= geo_in.meta.act;
         geo_ff.meta.pen    <= geo_in.meta.pen;
         geo_ff.ma          <= geo_in.ma;
         geo_ff.mb          <= geo_in.mb;
      end
   end

   assign geo = geo_ff;

endmodule

// ===== rtl/core/aabb_scale.sv =====
module aabb_scale (
   input  logic                                clock,
   input  logic                                en,
   input  logic [7:0]                          rest,
   input  aabb_pkg::aabb_geo_type              geo,
   output logic [aabb_pkg::NUM_WIDTH-1:0]      num_a,
   output logic [aabb_pkg::NUM_WIDTH-1:0]      num_b,
   output logic [aabb_pkg::DEN_WIDTH-1:0]      den,
   output logic [aabb_pkg::DEN_WIDTH-1:0]      half
);

   logic [24:0] pa_ff, pb_ff;
   logic [15:0] pen_ff;
   logic [16:0] msum_ff;
   logic [aabb_pkg::NUM_WIDTH-1:0] na_ff, nb_ff;
   logic [aabb_pkg::DEN_WIDTH-1:0] den_ff, half_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff   <= geo.ma * {1'b1, rest};
         pb_ff   <= geo.mb * {1'b1, rest};
         pen_ff  <= geo.meta.pen;
         msum_ff <= {1'b0, geo.ma} + {1'b0, geo.mb};
         na_ff   <= aabb_pkg::NUM_WIDTH'(pa_ff) * aabb_pkg::NUM_WIDTH'(pen_ff);
         nb_ff   <= aabb_pkg::NUM_WIDTH'(pb_ff) * aabb_pkg::NUM_WIDTH'(pen_ff);
         den_ff  <= aabb_pkg::DEN_WIDTH'(aabb_pkg::DEN_WIDTH'(msum_ff) * aabb_pkg::DEN_SCALE);
         half_ff <= aabb_pkg::DEN_WIDTH'(aabb_pkg::DEN_WIDTH'(msum_ff) * aabb_pkg::HALF_SCALE);
      end
   end

   assign num_a = na_ff;
   assign num_b = nb_ff;
   assign den   = den_ff;
   assign half  = half_ff;

endmodule

// ===== rtl/core/aabb_div.sv =====
module aabb_div (
   input  logic                                clock,
   input  logic                                en,
   input  logic [aabb_pkg::NUM_WIDTH-1:0]      num,
   input  logic [aabb_pkg::DEN_WIDTH-1:0]      half,
   input  logic [aabb_pkg::DEN_WIDTH-1:0]      den,
   output logic [aabb_pkg::QUO_WIDTH-1:0]      quo
);

   localparam int NW = aabb_pkg::NUM_WIDTH;
   localparam int DW = aabb_pkg::DEN_WIDTH;
   localparam int QW = aabb_pkg::QUO_WIDTH;
   localparam int CW = DW + QW + 1;

   logic [NW-1:0] rem_ff [0:QW-1];
   logic [DW-1:0] d_ff   [0:QW-1];
   logic [QW-1:0] q_ff   [0:QW];
   logic [NW-1:0] rem_in [0:QW-1];
   logic [QW-1:0] bit_in;
   logic [CW-1:0] trial  [0:QW-1];

   // one quotient bit per stage, most significant first
   always_comb begin
      for (int i = 0; i < QW; i++) begin
         trial[i]  = CW'(rem_ff[i]) - (CW'(d_ff[i]) << (QW - 1 - i));
         bit_in[i] = !trial[i][CW-1];
         rem_in[i] = bit_in[i] ? NW'(trial[i]) : rem_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num + NW'(half);
         d_ff[0]   <= den;
         q_ff[0]   <= '0;
         for (int i = 0; i < QW - 1; i++) begin
            rem_ff[i+1] <= rem_in[i];
            d_ff[i+1]   <= d_ff[i];
         end
         for (int i = 0; i < QW; i++) begin
            q_ff[i+1] <= {q_ff[i][QW-2:0], bit_in[i]};
         end
      end
   end

   assign quo = q_ff[QW];

endmodule

// ===== rtl/core/aabb_collision_resolve.sv =====
// Two-box AABB hit test and position correction, one request per cycle while
// no result is stalled. The pipeline has one geometry stage, two multiply
// stages, a rounding add and one restoring-division stage per quotient bit,
// then the result register. The whole pipeline holds while a result is
// stalled; req_stall follows rsp_stall in that case. restitution resets to
// 26 and should be written only while no request is in flight.
module aabb_collision_resolve (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [7:0]         csr_restitution,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_a_center_x,
   input  logic signed [15:0] req_a_center_y,
   input  logic [14:0]        req_a_width,
   input  logic [14:0]        req_a_height,
   input  logic signed [15:0] req_b_center_x,
   input  logic signed [15:0] req_b_center_y,
   input  logic [14:0]        req_b_width,
   input  logic [14:0]        req_b_height,
   input  logic [15:0]        req_a_mass,
   input  logic [15:0]        req_b_mass,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic               rsp_normal_axis,
   output logic               rsp_normal_negative,
   output logic [15:0]        rsp_penetration,
   output logic signed [15:0] rsp_a_shift_x,
   output logic signed [15:0] rsp_a_shift_y,
   output logic signed [15:0] rsp_b_shift_x,
   output logic signed [15:0] rsp_b_shift_y
);

   localparam int QW  = aabb_pkg::QUO_WIDTH;
   localparam int LAT = QW + 3;

   logic [7:0] rest_ff;
   logic       adv;
   aabb_pkg::aabb_geo_type geo;
   aabb_pkg::aabb_meta_type meta_ff [0:LAT-1];
   aabb_pkg::aabb_meta_type tail;
   logic [aabb_pkg::NUM_WIDTH-1:0] num_a, num_b;
   logic [aabb_pkg::DEN_WIDTH-1:0] den, half;
   logic [QW-1:0] qa, qb;
   logic [15:0] sa, sb;

   logic        vld_ff, hit_ff, axis_ff, neg_ff;
   logic [15:0] pen_ff, ax_ff, ay_ff, bx_ff, by_ff;

   // hold everything while the result register is stalled
   assign adv = !(vld_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff <= 8'd26;
      end else if (csr_we) begin
         rest_ff <= csr_restitution;
      end
   end

   aabb_geom u_geom (
      .clock (clock), .reset (reset), .en (adv), .vld_in (req_valid),
      .a_cx (req_a_center_x), .a_cy (req_a_center_y),
      .a_w (req_a_width), .a_h (req_a_height),
      .b_cx (req_b_center_x), .b_cy (req_b_center_y),
      .b_w (req_b_width), .b_h (req_b_height),
      .a_m (req_a_mass), .b_m (req_b_mass), .geo (geo)
   );

   aabb_scale u_scale (
      .clock (clock), .en (adv), .rest (rest_ff), .geo (geo),
      .num_a (num_a), .num_b (num_b), .den (den), .half (half)
   );

   aabb_div u_div_a (
      .clock (clock), .en (adv), .num (num_a), .half (half), .den (den), .quo (qa)
   );

   aabb_div u_div_b (
      .clock (clock), .en (adv), .num (num_b), .half (half), .den (den), .quo (qb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) meta_ff[i].vld <= 1'b0;
      end else if (adv) begin
         meta_ff[0].vld <= geo.meta.vld;
         for (int i = 1; i < LAT; i++) meta_ff[i].vld <= meta_ff[i-1].vld;
      end
      if (adv) begin
         meta_ff[0].hit    <= geo.meta.hit;
         meta_ff[0].axis_y <= geo.meta.axis_y;
         meta_ff[0].neg    <= geo.meta.neg;
         meta_ff[0].act    <= geo.meta.act;
         meta_ff[0].pen    <= geo.meta.pen;
         for (int i = 1; i < LAT; i++) begin
            meta_ff[i].hit    <= meta_ff[i-1].hit;
            meta_ff[i].axis_y <= meta_ff[i-1].axis_y;
            meta_ff[i].neg    <= meta_ff[i-1].neg;
            meta_ff[i].act    <= meta_ff[i-1].act;
            meta_ff[i].pen    <= meta_ff[i-1].pen;
         end
      end
   end

   assign tail = meta_ff[LAT-1];

   always_comb begin
      sa = tail.act ? aabb_pkg::sat16(qa, tail.neg) : 16'd0;
      sb = tail.act ? aabb_pkg::sat16(qb, !tail.neg) : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= tail.vld;
      end
      if (adv) begin
         hit_ff  <= tail.hit;
         axis_ff <= tail.axis_y;
         neg_ff  <= tail.neg;
         pen_ff  <= tail.pen;
         ax_ff   <= tail.axis_y ? 16'd0 : sa;
         ay_ff   <= tail.axis_y ? sa : 16'd0;
         bx_ff   <= tail.axis_y ? 16'd0 : sb;
         by_ff   <= tail.axis_y ? sb : 16'd0;
      end
   end

   assign rsp_valid           = vld_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_normal_axis     = axis_ff;
   assign rsp_normal_negative = neg_ff;
   assign rsp_penetration     = pen_ff;
   assign rsp_a_shift_x       = ax_ff;
   assign rsp_a_shift_y       = ay_ff;
   assign rsp_b_shift_x       = bx_ff;
   assign rsp_b_shift_y       = by_ff;

endmodule

// ===== dv/testbench.sv =====
module testbench;

   typedef struct {
      logic signed [15:0] ax, ay, bx, by;
      logic [14:0]        aw, ah, bw, bh;
      logic [15:0]        ma, mb;
   } box_pair_type;

   typedef struct {
      logic               hit, axis_y, neg;
      logic [15:0]        pen;
      logic signed [15:0] asx, asy, bsx, bsy;
   } resolve_type;

   typedef struct {
      box_pair_type pair;
      bit           known;
      resolve_type  res;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [7:0] csr_restitution = 0;
   logic req_valid = 0;
   logic req_stall;
   logic signed [15:0] req_a_center_x = 0, req_a_center_y = 0;
   logic signed [15:0] req_b_center_x = 0, req_b_center_y = 0;
   logic [14:0] req_a_width = 0, req_a_height = 0, req_b_width = 0, req_b_height = 0;
   logic [15:0] req_a_mass = 0, req_b_mass = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_hit, rsp_normal_axis, rsp_normal_negative;
   logic [15:0] rsp_penetration;
   logic signed [15:0] rsp_a_shift_x, rsp_a_shift_y, rsp_b_shift_x, rsp_b_shift_y;

   aabb_collision_resolve uut (.*);

   localparam int LATENCY = 23;

   logic [7:0]  restitution_q = 8'd26;
   resolve_type pending_results[$];
   int          errors = 0;
   int          hits_seen = 0;
   int          results_seen = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   stim_row_type directed[$];
   resolve_type  none;

   initial forever #6 clock = ~clock;

   initial begin
      #60000000;
      $display("timeout");
      $display("status: fail");
      $finish;
   end

   function automatic logic signed [15:0] correction(logic [15:0] m, logic [15:0] pen,
                                                      logic [16:0] msum, bit ng);
      logic [63:0] num, den, q;
      if (msum == 0) return 16'sd0;
      num = 64'(m) * (64'd256 + 64'(restitution_q)) * 64'(pen);
      den = 64'(msum) * 64'd2560;
      q = (num + den / 2) / den;
      if (ng) return (q >= 32768) ? -16'sd32768 : -$signed(16'(q));
      return (q >= 32767) ? 16'sd32767 : 16'(q);
   endfunction

   function automatic resolve_type resolve_pair(box_pair_type p);
      resolve_type r;
      longint ax, ay, bx, by, aw, ah, bw, bh, dx, dy, ox, oy;
      logic [16:0] msum;
      logic signed [15:0] sa, sb;
      ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
      aw = p.aw; ah = p.ah; bw = p.bw; bh = p.bh;
      r = '{default: 0};
      dx = ax - bx; dy = ay - by;
      r.hit = !((2*ax + aw < 2*bx - bw) || (2*bx + bw < 2*ax - aw) ||
                (2*ay + ah < 2*by - bh) || (2*by + bh < 2*ay - ah));
      ox = aw + bw - (dx < 0 ? -dx : dx);
      oy = ah + bh - (dy < 0 ? -dy : dy);
      if (r.hit && ox > 0 && oy > 0) begin
         if (ox < oy) begin
            r.neg = dx < 0;
            r.pen = 16'(ox);
         end else begin
            r.axis_y = 1;
            r.neg = dy < 0;
            r.pen = 16'(oy);
         end
         msum = 17'(p.ma) + 17'(p.mb);
         sa = correction(p.ma, r.pen, msum, r.neg);
         sb = correction(p.mb, r.pen, msum, !r.neg);
         if (r.axis_y) begin
            r.asy = sa;
            r.bsy = sb;
         end else begin
            r.asx = sa;
            r.bsx = sb;
         end
      end
      return r;
   endfunction

   function automatic bit same_result(resolve_type x, resolve_type y);
      return x.hit == y.hit && x.axis_y == y.axis_y && x.neg == y.neg && x.pen == y.pen &&
             x.asx == y.asx && x.asy == y.asy && x.bsx == y.bsx && x.bsy == y.bsy;
   endfunction

   function automatic void add_row(box_pair_type p, bit known, resolve_type res);
      directed.insert(directed.size(), '{p, known, res});
   endfunction

   // sample results and compare with the oldest expectation
   always @(posedge clock) begin
      resolve_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_hit, rsp_normal_axis, rsp_normal_negative, rsp_penetration,
                 rsp_a_shift_x, rsp_a_shift_y, rsp_b_shift_x, rsp_b_shift_y};
         results_seen++;
         if (got.hit) hits_seen++;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: expected no result, actual hit=%0d", $time, got.hit);
         end else begin
            want = pending_results.pop_front();
            if (!same_result(want, got)) begin
               errors++;
               $display("%0t: expected hit=%0d ax=%0d neg=%0d pen=%0d a=(%0d,%0d) b=(%0d,%0d)",
                        $time, want.hit, want.axis_y, want.neg, want.pen,
                        want.asx, want.asy, want.bsx, want.bsy);
               $display("%0t: actual   hit=%0d ax=%0d neg=%0d pen=%0d a=(%0d,%0d) b=(%0d,%0d)",
                        $time, got.hit, got.axis_y, got.neg, got.pen,
                        got.asx, got.asy, got.bsx, got.bsy);
            end
         end
      end
   end

   // receiver backpressure
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   task automatic send_pair(box_pair_type p, resolve_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_a_center_x <= p.ax; req_a_center_y <= p.ay;
      req_b_center_x <= p.bx; req_b_center_y <= p.by;
      req_a_width <= p.aw; req_a_height <= p.ah;
      req_b_width <= p.bw; req_b_height <= p.bh;
      req_a_mass <= p.ma; req_b_mass <= p.mb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.insert(pending_results.size(), want);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_restitution(logic [7:0] e);
      csr_we <= 1;
      csr_restitution <= e;
      @(posedge clock);
      csr_we <= 0;
      restitution_q = e;
   endtask

   function automatic box_pair_type random_pair();
      box_pair_type p;
      int span;
      span = ($urandom_range(9) == 0) ? 32767 : 2047;
      p.aw = 15'($urandom_range(span)); p.ah = 15'($urandom_range(span));
      p.bw = 15'($urandom_range(span)); p.bh = 15'($urandom_range(span));
      p.ma = 16'($urandom); p.mb = 16'($urandom);
      if ($urandom_range(9) == 0) p.ma = 0;
      if ($urandom_range(9) == 0) p.mb = 0;
      p.ax = 16'($urandom); p.ay = 16'($urandom);
      if ($urandom_range(9) < 7) begin
         // place B near A so most pairs collide
         p.bx = p.ax + 16'($signed(17'($urandom_range(2*span)) - 17'(span)));
         p.by = p.ay + 16'($signed(17'($urandom_range(2*span)) - 17'(span)));
      end else begin
         p.bx = 16'($urandom); p.by = 16'($urandom);
      end
      return p;
   endfunction

   initial begin
      box_pair_type p;
      none = '{default: 0};
      // far apart, no hit
      add_row('{-16'sd32768, 0, 16'sd32767, 0, 1, 1, 1, 1, 1, 1}, 1, none);
      // all zero: touching degenerate boxes
      add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{1, 0, 0, 0, 0, 0, 0, 0});
      // identical boxes, equal overlap picks y, zero diff is positive
      add_row('{0, 0, 0, 0, 256, 256, 256, 256, 256, 256}, 0, none);
      // zero mass sum
      add_row('{0, 0, 0, 10, 512, 512, 512, 512, 0, 0}, 0, none);
      // extremes of size and mass
      add_row('{16'sd32767, 16'sd32767, 16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff,
                15'h7fff, 15'h7fff, 16'hffff, 16'hffff}, 0, none);
      add_row('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff,
                15'h7fff, 15'h7fff, 16'hffff, 0}, 0, none);
      add_row('{16'sh8000, 0, 16'sh8000, 0, 15'h7fff, 15'h7fff,
                15'h7fff, 15'h7fff, 0, 16'hffff}, 0, none);
      // x normal, both signs
      add_row('{-100, 0, 100, 0, 300, 4000, 300, 4000, 256, 512}, 0, none);
      add_row('{100, 0, -100, 0, 300, 4000, 300, 4000, 512, 256}, 0, none);
      // y normal negative
      add_row('{0, -50, 0, 50, 4000, 200, 4000, 200, 1, 1}, 0, none);
      // degenerate: zero width but touching
      add_row('{0, 0, 0, 0, 0, 100, 0, 100, 256, 256}, 1, '{1, 0, 0, 0, 0, 0, 0, 0});
      // just touching edges in x
      add_row('{0, 0, 100, 0, 100, 100, 100, 100, 256, 256}, 0, none);

      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].known)
            send_pair(directed[i].pair, directed[i].res);
         else
            send_pair(directed[i].pair, resolve_pair(directed[i].pair));
      end
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin set_restitution(8'd0);   send_idle_pct = 31; recv_idle_pct = 70; end
            1: begin set_restitution(8'd255); send_idle_pct = 70; recv_idle_pct = 31; end
            2: begin set_restitution(8'($urandom)); send_idle_pct = 0; recv_idle_pct = 0; end
            default: begin set_restitution(8'd26); send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         repeat (300) begin
            p = random_pair();
            send_pair(p, resolve_pair(p));
         end
         drain();
      end

      $display("covered %0d results, %0d hits, restitution 0/255/random/26 with stalls",
               results_seen, hits_seen);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/aabb_pkg.sv
rtl/core/aabb_geom.sv
rtl/core/aabb_scale.sv
rtl/core/aabb_div.sv
rtl/core/aabb_collision_resolve.sv
dv/testbench.sv
